// ===== hw/rtl/mbg_pkg.sv =====
// ----------------------------------------------------------------------------
// Maze generator package
// Field widths, command and result codes, direction codes and default sizes
// shared by the channel interfaces and the maze generator modules.
// ----------------------------------------------------------------------------
package mbg_pkg;

	// Payload field widths.
	localparam int CMD_W = 2;
	localparam int RND_W = 8;
	localparam int CRD_W = 6;
	localparam int ACT_W = 2;
	localparam int DIR_W = 2;
	localparam int N_DIR = 4;

	// Default sizes.
	localparam int DEF_GRID_ROWS   = 60;
	localparam int DEF_GRID_COLS   = 60;
	localparam int DEF_STACK_DEPTH = 900;

	// Request commands. The fourth code behaves as a query.
	localparam logic [CMD_W-1:0] CMD_RESTART = 2'd0;
	localparam logic [CMD_W-1:0] CMD_STEP    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

	// Result actions.
	localparam logic [ACT_W-1:0] ACT_CARVED = 2'd0;
	localparam logic [ACT_W-1:0] ACT_BACK   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_DONE   = 2'd2;
	localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd3;

	// Neighbor directions, in the order they are examined.
	localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic [CRD_W-1:0] pos_row;
		logic [CRD_W-1:0] pos_col;
		logic [CRD_W-1:0] pas_row;
		logic [CRD_W-1:0] pas_col;
		logic             cell_open;
	} res_t;

endpackage

// ===== hw/rtl/mbg_if.sv =====
// ----------------------------------------------------------------------------
// Maze generator channels
// Valid/ready channels for the maze generator requests and results.
// ----------------------------------------------------------------------------
interface mbg_req_if import mbg_pkg::*;;
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic [RND_W-1:0] random_value;
	logic [CRD_W-1:0] query_row;
	logic [CRD_W-1:0] query_col;

	modport source (output valid, command, random_value, query_row, query_col,
		input ready);
	modport sink (input valid, command, random_value, query_row, query_col,
		output ready);
endinterface

interface mbg_rsp_if import mbg_pkg::*;;
	logic             valid;
	logic             ready;
	logic [ACT_W-1:0] action;
	logic [CRD_W-1:0] pos_row;
	logic [CRD_W-1:0] pos_col;
	logic [CRD_W-1:0] passage_row;
	logic [CRD_W-1:0] passage_col;
	logic             cell_open;

	modport source (output valid, action, pos_row, pos_col, passage_row, passage_col,
		cell_open, input ready);
	modport sink (input valid, action, pos_row, pos_col, passage_row, passage_col,
		cell_open, output ready);
endinterface

// ===== hw/rtl/maze_backtracker_generator.sv =====
// ----------------------------------------------------------------------------
// Maze backtracker generator
// Depth-first maze carving over a cell bitmap RAM with an explicit path
// stack RAM, driven one command at a time.
// ----------------------------------------------------------------------------
// The block holds one open/closed bit per grid cell in a RAM of
// GRID_ROWS*GRID_COLS entries and the carving path in a stack RAM of
// STACK_DEPTH entries; both have a single write port and a registered read.
// After reset the bitmap is swept to zero, one cell per cycle, and the request
// channel stays not-ready until the sweep is through. Requests are taken one
// at a time. A restart runs the same sweep. A step reads its four neighbors
// through the single bitmap read port, one per cycle, and then either writes
// the wall and then the new room or reads the stack once. Results sit in an
// output register, so a new request may be accepted while the previous result
// waits to be taken.
// ----------------------------------------------------------------------------
module maze_backtracker_generator import mbg_pkg::*; #(
	parameter int GRID_ROWS   = DEF_GRID_ROWS,
	parameter int GRID_COLS   = DEF_GRID_COLS,
	parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	mbg_req_if.sink   req,
	mbg_rsp_if.source rsp
);

	localparam int RW     = $clog2(GRID_ROWS);
	localparam int CW     = $clog2(GRID_COLS);
	localparam int MAP_N  = GRID_ROWS * GRID_COLS;
	localparam int MAP_AW = $clog2(MAP_N);
	localparam int SAW    = $clog2(STACK_DEPTH);
	localparam int SPW    = $clog2(STACK_DEPTH + 1);
	localparam int STK_W  = RW + CW;

	// Sequencer states.
	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_OPEN0  = 4'd1;
	localparam logic [3:0] ST_IDLE   = 4'd2;
	localparam logic [3:0] ST_QRD    = 4'd3;
	localparam logic [3:0] ST_QRES   = 4'd4;
	localparam logic [3:0] ST_NRD    = 4'd5;
	localparam logic [3:0] ST_NLAST  = 4'd6;
	localparam logic [3:0] ST_PICK   = 4'd7;
	localparam logic [3:0] ST_CARVE1 = 4'd8;
	localparam logic [3:0] ST_CARVE2 = 4'd9;
	localparam logic [3:0] ST_POP    = 4'd10;
	localparam logic [3:0] ST_OUT    = 4'd11;

	// Linear bitmap address of a cell.
	function automatic logic [MAP_AW-1:0] cell_addr(input logic [RW-1:0] r,
		input logic [CW-1:0] c);
		return MAP_AW'(r) * MAP_AW'(GRID_COLS) + MAP_AW'(c);
	endfunction

	// Coordinates go out on fixed six-bit fields.
	function automatic logic [CRD_W-1:0] row6(input logic [RW-1:0] v);
		logic [RW+CRD_W-1:0] t;
		t = {{CRD_W{1'b0}}, v};
		return t[CRD_W-1:0];
	endfunction

	function automatic logic [CRD_W-1:0] col6(input logic [CW-1:0] v);
		logic [CW+CRD_W-1:0] t;
		t = {{CRD_W{1'b0}}, v};
		return t[CRD_W-1:0];
	endfunction

	// Control state.
	logic [3:0]        st_q;
	logic              fin_q;
	logic              boot_q;
	logic [RW-1:0]     cur_row_q;
	logic [CW-1:0]     cur_col_q;
	logic [SPW-1:0]    sp_q;
	logic [MAP_AW-1:0] clr_q;
	logic [DIR_W-1:0]  k_q;
	logic              pend_s1;
	logic              out_vld_q;

	// Datapath registers.
	logic [RND_W-1:0]  rnd_q;
	logic [RW-1:0]     q_row_q;
	logic [CW-1:0]     q_col_q;
	logic              q_ok_q;
	logic [N_DIR-1:0]  cand_q;
	logic [DIR_W-1:0]  dir_s1;
	logic              ok_s1;
	logic [RW-1:0]     nxt_row_q;
	logic [CW-1:0]     nxt_col_q;
	logic [RW-1:0]     wall_row_q;
	logic [CW-1:0]     wall_col_q;
	res_t              res_q;
	res_t              out_q;

	// Bitmap and stack RAM ports.
	logic              map_we;
	logic [MAP_AW-1:0] map_waddr;
	logic [0:0]        map_wdata;
	logic [MAP_AW-1:0] map_raddr;
	logic [0:0]        map_rdata;
	logic              stk_we;
	logic [SAW-1:0]    stk_waddr;
	logic [STK_W-1:0]  stk_wdata;
	logic [SAW-1:0]    stk_raddr;
	logic [STK_W-1:0]  stk_rdata;
	logic [SPW-1:0]    sp_dec;

	// Neighbor arithmetic.
	logic [DIR_W-1:0]  sel_dir;
	logic [RW:0]       row_up;
	logic [RW:0]       row_dn;
	logic [CW:0]       col_lf;
	logic [CW:0]       col_rt;
	logic              nb_ok;
	logic [RW-1:0]     nb_row;
	logic [CW-1:0]     nb_col;
	logic [RW-1:0]     nbw_row;
	logic [CW-1:0]     nbw_col;
	logic              pick_any;
	logic [DIR_W-1:0]  pick_dir;

	// Query coordinates widened so they compare against any grid size.
	logic [RW+CRD_W-1:0] qr_ext;
	logic [CW+CRD_W-1:0] qc_ext;

	logic              acc;
	logic              out_free;
	logic [RW-1:0]     rd_row;
	logic [CW-1:0]     rd_col;
	logic [RW-1:0]     wr_row;
	logic [CW-1:0]     wr_col;

	assign acc      = req.valid && req.ready;
	assign req.ready = (st_q == ST_IDLE);
	assign out_free = !out_vld_q || rsp.ready;

	assign qr_ext = {{RW{1'b0}}, req.query_row};
	assign qc_ext = {{CW{1'b0}}, req.query_col};

	mbg_pick u_pick (
		.cand (cand_q),
		.rnd  (rnd_q),
		.any  (pick_any),
		.dir  (pick_dir)
	);

	// The neighbor unit serves the read sweep and, in the pick state, the chosen
	// direction; the wall cell is the one halfway to the neighbor.
	assign sel_dir = (st_q == ST_PICK) ? pick_dir : k_q;
	assign row_up  = {1'b0, cur_row_q} - (RW+1)'(2);
	assign row_dn  = {1'b0, cur_row_q} + (RW+1)'(2);
	assign col_lf  = {1'b0, cur_col_q} - (CW+1)'(2);
	assign col_rt  = {1'b0, cur_col_q} + (CW+1)'(2);

	always_comb begin
		case (sel_dir)
			DIR_UP: begin
				nb_ok   = (cur_row_q >= RW'(2));
				nb_row  = row_up[RW-1:0];
				nb_col  = cur_col_q;
				nbw_row = cur_row_q - RW'(1);
				nbw_col = cur_col_q;
			end
			DIR_DOWN: begin
				nb_ok   = (row_dn < (RW+1)'(GRID_ROWS));
				nb_row  = row_dn[RW-1:0];
				nb_col  = cur_col_q;
				nbw_row = cur_row_q + RW'(1);
				nbw_col = cur_col_q;
			end
			DIR_LEFT: begin
				nb_ok   = (cur_col_q >= CW'(2));
				nb_row  = cur_row_q;
				nb_col  = col_lf[CW-1:0];
				nbw_row = cur_row_q;
				nbw_col = cur_col_q - CW'(1);
			end
			default: begin
				nb_ok   = (col_rt < (CW+1)'(GRID_COLS));
				nb_row  = cur_row_q;
				nb_col  = col_rt[CW-1:0];
				nbw_row = cur_row_q;
				nbw_col = cur_col_q + CW'(1);
			end
		endcase
	end

	// Bitmap port muxing. Reads happen only after the previous request has
	// finished all its writes, so no forwarding is needed.
	assign rd_row = (st_q == ST_QRD) ? q_row_q : nb_row;
	assign rd_col = (st_q == ST_QRD) ? q_col_q : nb_col;
	assign wr_row = (st_q == ST_CARVE1) ? wall_row_q : nxt_row_q;
	assign wr_col = (st_q == ST_CARVE1) ? wall_col_q : nxt_col_q;
	assign map_raddr = cell_addr(rd_row, rd_col);

	always_comb begin
		case (st_q)
			ST_CLEAR:  map_waddr = clr_q;
			ST_OPEN0:  map_waddr = '0;
			default:   map_waddr = cell_addr(wr_row, wr_col);
		endcase
	end

	assign map_we = (st_q == ST_CLEAR) || (st_q == ST_OPEN0) ||
		(st_q == ST_CARVE1) || (st_q == ST_CARVE2);
	assign map_wdata = (st_q == ST_CLEAR) ? 1'b0 : 1'b1;

	// The push saturates when the stack is full.
	assign sp_dec    = sp_q - SPW'(1);
	assign stk_we    = (st_q == ST_CARVE2) && (sp_q < SPW'(STACK_DEPTH));
	assign stk_waddr = sp_q[SAW-1:0];
	assign stk_wdata = {cur_row_q, cur_col_q};
	assign stk_raddr = sp_dec[SAW-1:0];

	mbg_ram #(
		.DEPTH (MAP_N),
		.WIDTH (1)
	) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	mbg_ram #(
		.DEPTH (STACK_DEPTH),
		.WIDTH (STK_W)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// Sequencer and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_CLEAR;
			fin_q     <= 1'b1;
			boot_q    <= 1'b1;
			cur_row_q <= '0;
			cur_col_q <= '0;
			sp_q      <= '0;
			clr_q     <= '0;
			k_q       <= DIR_UP;
			pend_s1   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (st_q == ST_OUT && out_free) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + MAP_AW'(1);
					if (clr_q == MAP_AW'(MAP_N - 1)) begin
						// The sweep after reset produces no result.
						if (boot_q) begin
							boot_q <= 1'b0;
							st_q   <= ST_IDLE;
						end else begin
							st_q <= ST_OPEN0;
						end
					end
				end
				ST_OPEN0: begin
					cur_row_q <= '0;
					cur_col_q <= '0;
					sp_q      <= '0;
					fin_q     <= 1'b0;
					st_q      <= ST_OUT;
				end
				ST_IDLE: begin
					if (acc) begin
						k_q     <= DIR_UP;
						pend_s1 <= 1'b0;
						case (req.command)
							CMD_RESTART: begin
								clr_q <= '0;
								st_q  <= ST_CLEAR;
							end
							CMD_STEP: begin
								st_q <= fin_q ? ST_OUT : ST_NRD;
							end
							default: begin
								st_q <= ST_QRD;
							end
						endcase
					end
				end
				ST_QRD: begin
					st_q <= ST_QRES;
				end
				ST_QRES: begin
					st_q <= ST_OUT;
				end
				ST_NRD: begin
					pend_s1 <= 1'b1;
					k_q     <= k_q + DIR_W'(1);
					if (k_q == DIR_RIGHT) begin
						st_q <= ST_NLAST;
					end
				end
				ST_NLAST: begin
					pend_s1 <= 1'b0;
					st_q    <= ST_PICK;
				end
				ST_PICK: begin
					if (pick_any) begin
						st_q <= ST_CARVE1;
					end else if (sp_q == '0) begin
						// Dead end at the start room: the maze is complete.
						fin_q <= 1'b1;
						st_q  <= ST_OUT;
					end else begin
						st_q <= ST_POP;
					end
				end
				ST_CARVE1: begin
					st_q <= ST_CARVE2;
				end
				ST_CARVE2: begin
					if (stk_we) begin
						sp_q <= sp_q + SPW'(1);
					end
					cur_row_q <= nxt_row_q;
					cur_col_q <= nxt_col_q;
					st_q      <= ST_OUT;
				end
				ST_POP: begin
					sp_q      <= sp_dec;
					cur_row_q <= stk_rdata[STK_W-1:CW];
					cur_col_q <= stk_rdata[CW-1:0];
					st_q      <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request fields, neighbor results and the pending result.
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (acc) begin
					rnd_q   <= req.random_value;
					q_row_q <= qr_ext[RW-1:0];
					q_col_q <= qc_ext[CW-1:0];
					q_ok_q  <= (qr_ext < (RW+CRD_W)'(GRID_ROWS)) &&
						(qc_ext < (CW+CRD_W)'(GRID_COLS));
					cand_q  <= '0;
					res_q   <= '{act: ACT_DONE, pos_row: row6(cur_row_q),
						pos_col: col6(cur_col_q), pas_row: '0, pas_col: '0,
						cell_open: 1'b0};
				end
			end
			ST_OPEN0: begin
				res_q <= '{act: ACT_DONE, pos_row: '0, pos_col: '0, pas_row: '0,
					pas_col: '0, cell_open: 1'b0};
			end
			ST_QRES: begin
				res_q <= '{act: ACT_QUERY, pos_row: row6(cur_row_q),
					pos_col: col6(cur_col_q), pas_row: '0, pas_col: '0,
					cell_open: q_ok_q & map_rdata[0]};
			end
			ST_NRD, ST_NLAST: begin
				dir_s1 <= k_q;
				ok_s1  <= nb_ok;
				// Bit data comes back from the registered read in the cycle after its address.
				if (pend_s1) begin
					cand_q[dir_s1] <= ok_s1 & ~map_rdata[0];
				end
			end
			ST_PICK: begin
				nxt_row_q  <= nb_row;
				nxt_col_q  <= nb_col;
				wall_row_q <= nbw_row;
				wall_col_q <= nbw_col;
			end
			ST_CARVE2: begin
				res_q <= '{act: ACT_CARVED, pos_row: row6(nxt_row_q),
					pos_col: col6(nxt_col_q), pas_row: row6(wall_row_q),
					pas_col: col6(wall_col_q), cell_open: 1'b0};
			end
			ST_POP: begin
				res_q <= '{act: ACT_BACK, pos_row: row6(stk_rdata[STK_W-1:CW]),
					pos_col: col6(stk_rdata[CW-1:0]), pas_row: '0, pas_col: '0,
					cell_open: 1'b0};
			end
			ST_OUT: begin
				if (out_free) begin
					out_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.action      = out_q.act;
	assign rsp.pos_row     = out_q.pos_row;
	assign rsp.pos_col     = out_q.pos_col;
	assign rsp.passage_row = out_q.pas_row;
	assign rsp.passage_col = out_q.pas_col;
	assign rsp.cell_open   = out_q.cell_open;

	// Once finished, the bitmap is written only by a restart sweep.
	a_fin_no_write : assert property (@(posedge clk) disable iff (!arst_n)
		(fin_q && st_q != ST_CLEAR && st_q != ST_OPEN0) |-> !map_we)
		else $error("bitmap written while the maze is finished");

	// The saturating push never lets the stack count pass the depth.
	a_sp_bound : assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CARVE2) |=> (sp_q <= SPW'(STACK_DEPTH)))
		else $error("stack count beyond depth");

	// Requests are handled one at a time.
	a_one_req : assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while another is in progress");

endmodule

// ===== hw/rtl/mbg_ram.sv =====
// ----------------------------------------------------------------------------
// Maze generator RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mbg_ram import mbg_pkg::*; #(
	parameter int DEPTH = DEF_STACK_DEPTH,
	parameter int WIDTH = 2 * CRD_W,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/mbg_pick.sv =====
// ----------------------------------------------------------------------------
// Maze generator neighbor pick
// Chooses one candidate neighbor: the random value modulo the candidate
// count selects among the set bits of the candidate mask, lowest first.
// ----------------------------------------------------------------------------
module mbg_pick import mbg_pkg::*; (
	input  logic [N_DIR-1:0] cand,
	input  logic [RND_W-1:0] rnd,
	output logic             any,
	output logic [DIR_W-1:0] dir
);

	logic [2:0]       cnt;
	logic [2*RND_W:0] prod;
	logic [RND_W-1:0] quo;
	logic [RND_W-1:0] tri3;
	logic [RND_W-1:0] rem3;
	logic [DIR_W-1:0] idx;
	logic [2:0]       seen;
	logic             found;

	assign cnt = 3'($countones(cand));
	assign any = (cnt != 3'd0);

	// Remainder by three through the reciprocal 171/512, exact for 8 bits.
	assign prod = {{(RND_W+1){1'b0}}, rnd} * (2*RND_W+1)'(171);
	assign quo  = prod[2*RND_W:RND_W+1];
	assign tri3 = quo + {quo[RND_W-2:0], 1'b0};
	assign rem3 = rnd - tri3;

	always_comb begin
		case (cnt)
			3'd2:    idx = {1'b0, rnd[0]};
			3'd3:    idx = rem3[DIR_W-1:0];
			3'd4:    idx = rnd[DIR_W-1:0];
			default: idx = '0;
		endcase
	end

	always_comb begin
		dir   = DIR_UP;
		seen  = '0;
		found = 1'b0;
		for (int k = 0; k < N_DIR; k++) begin
			if (cand[k]) begin
				if (!found && seen == {1'b0, idx}) begin
					dir   = DIR_W'(k);
					found = 1'b1;
				end
				seen = seen + 3'd1;
			end
		end
	end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Maze backtracker generator testbench
// Sends restart, step and query requests through the request channel and
// checks every result, field by field, against a behavioral model of the
// depth-first carving or a hand-typed result. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb import mbg_pkg::*;;

	localparam int ROWS  = DEF_GRID_ROWS;
	localparam int COLS  = DEF_GRID_COLS;
	localparam int DEPTH = DEF_STACK_DEPTH;

	// The slowest request is a restart, which sweeps the whole bitmap.
	// Add the longest sender gap and the longest receiver stall and take
	// the sum several times over.
	localparam int IDLE_LIMIT = 20000;
	localparam int PRINT_CAP  = 40;

	// The fourth command code has no name in the package; it acts as a query.
	localparam logic [CMD_W-1:0] CMD_QUERY_ALT = 2'd3;

	// Results that can be written down without running the model.
	localparam res_t DONE_HOME   = '{ACT_DONE, 6'd0, 6'd0, 6'd0, 6'd0, 1'b0};
	localparam res_t SHUT_HOME   = '{ACT_QUERY, 6'd0, 6'd0, 6'd0, 6'd0, 1'b0};
	localparam res_t OPEN_HOME   = '{ACT_QUERY, 6'd0, 6'd0, 6'd0, 6'd0, 1'b1};
	localparam res_t FIRST_CARVE = '{ACT_CARVED, 6'd2, 6'd0, 6'd1, 6'd0, 1'b0};
	localparam res_t OPEN_NEAR   = '{ACT_QUERY, 6'd2, 6'd0, 6'd0, 6'd0, 1'b1};
	localparam res_t NOT_KNOWN   = '0;

	// A room saved on the path stack.
	typedef struct packed {
		logic [CRD_W-1:0] r;
		logic [CRD_W-1:0] c;
	} spot_t;

	// One request as the sender sees it. When known is set, want holds the
	// result typed in by hand and it replaces the model's answer.
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [RND_W-1:0] rnd;
		logic [CRD_W-1:0] qr;
		logic [CRD_W-1:0] qc;
		logic             known;
		res_t             want;
	} stim_t;

	logic clk;
	logic arst_n;

	mbg_req_if req_ch ();
	mbg_rsp_if rsp_ch ();

	maze_backtracker_generator uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// ------------------------------------------------------------------
	// Model state: the cell bitmap, the path of rooms back to the origin,
	// the current room and the finished flag, all as they stand after
	// reset. The bitmap starts closed and the flag starts set, so a step
	// before the first restart answers finished at the origin.
	// ------------------------------------------------------------------
	bit    maze_open [ROWS][COLS];
	spot_t trail [$];
	int    cur_row   = 0;
	int    cur_col   = 0;
	bit    maze_done = 1'b1;

	// Results still owed by the block, oldest first.
	res_t owed [$];

	// Side note that travels with the request on the channel.
	stim_t req_note;

	// When set, neither side inserts gaps or stalls.
	bit calm;

	stim_t script [25];

	int err_count   = 0;
	int n_requests  = 0;
	int n_results   = 0;
	int n_carves    = 0;
	int n_backs     = 0;
	int mazes_built = 0;
	int quiet       = 0;

	// Applies one request to the model and returns the result it causes.
	function automatic res_t predict_maze(input logic [CMD_W-1:0] cmd,
		input logic [RND_W-1:0] rnd, input logic [CRD_W-1:0] qr,
		input logic [CRD_W-1:0] qc);
		res_t  r;
		int    tr [N_DIR];
		int    tc [N_DIR];
		int    n;
		int    k;
		int    nr;
		int    nc;
		int    wr;
		int    wc;
		int    pick;
		spot_t back;
		r = '0;
		if (cmd == CMD_RESTART) begin
			foreach (maze_open[i, j]) maze_open[i][j] = 1'b0;
			maze_open[0][0] = 1'b1;
			cur_row = 0;
			cur_col = 0;
			trail.delete();
			maze_done = 1'b0;
			r.act = ACT_DONE;
		end else if (cmd != CMD_STEP) begin
			// Both query codes land here; outside the grid reads as closed.
			r.act = ACT_QUERY;
			if (int'(qr) < ROWS && int'(qc) < COLS)
				r.cell_open = maze_open[qr][qc];
		end else if (maze_done) begin
			r.act = ACT_DONE;
		end else begin
			// Collect the unopened rooms two cells away, up, down, left, right.
			n = 0;
			for (k = 0; k < N_DIR; k++) begin
				nr = cur_row;
				nc = cur_col;
				case (DIR_W'(k))
					DIR_UP:    nr = cur_row - 2;
					DIR_DOWN:  nr = cur_row + 2;
					DIR_LEFT:  nc = cur_col - 2;
					DIR_RIGHT: nc = cur_col + 2;
					default:   nr = cur_row;
				endcase
				if (nr >= 0 && nc >= 0 && nr < ROWS && nc < COLS
					&& !maze_open[nr][nc]) begin
					tr[n] = nr;
					tc[n] = nc;
					n++;
				end
			end
			if (n > 0) begin
				pick = int'(rnd) % n;
				nr = tr[pick];
				nc = tc[pick];
				wr = (cur_row + nr) / 2;
				wc = (cur_col + nc) / 2;
				maze_open[wr][wc] = 1'b1;
				maze_open[nr][nc] = 1'b1;
				// A full stack drops the push but the carve goes ahead.
				if (trail.size() < DEPTH) begin
					back.r = CRD_W'(cur_row);
					back.c = CRD_W'(cur_col);
					trail.push_back(back);
				end
				cur_row = nr;
				cur_col = nc;
				r.act = ACT_CARVED;
				r.pas_row = CRD_W'(wr);
				r.pas_col = CRD_W'(wc);
			end else if (trail.size() == 0) begin
				// Dead end at the origin with nothing to return to.
				maze_done = 1'b1;
				mazes_built++;
				r.act = ACT_DONE;
			end else begin
				back = trail.pop_back();
				cur_row = int'(back.r);
				cur_col = int'(back.c);
				r.act = ACT_BACK;
			end
		end
		r.pos_row = CRD_W'(cur_row);
		r.pos_col = CRD_W'(cur_col);
		return r;
	endfunction

	task automatic report_error(input string what);
		err_count++;
		if (err_count <= PRINT_CAP)
			$display("mismatch: result %0d: %s", n_results, what);
	endtask

	task automatic compare_result(input res_t got, input res_t want);
		if (got.act != want.act)
			report_error($sformatf("action %0d, expected %0d", got.act, want.act));
		if (got.pos_row != want.pos_row)
			report_error($sformatf("pos_row %0d, expected %0d", got.pos_row,
				want.pos_row));
		if (got.pos_col != want.pos_col)
			report_error($sformatf("pos_col %0d, expected %0d", got.pos_col,
				want.pos_col));
		if (got.pas_row != want.pas_row)
			report_error($sformatf("passage_row %0d, expected %0d", got.pas_row,
				want.pas_row));
		if (got.pas_col != want.pas_col)
			report_error($sformatf("passage_col %0d, expected %0d", got.pas_col,
				want.pas_col));
		if (got.cell_open != want.cell_open)
			report_error($sformatf("cell_open %0d, expected %0d", got.cell_open,
				want.cell_open));
	endtask

	// Gap length: mostly none or short, now and then long.
	function automatic int idle_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// Builds a random request of the given command. Queries aim near the
	// current room half of the time, where the open/closed answer is least
	// predictable, and anywhere in the 6-bit range otherwise.
	function automatic stim_t roll_request(input logic [CMD_W-1:0] cmd);
		stim_t s;
		s = '0;
		s.cmd = cmd;
		s.rnd = RND_W'($urandom_range(0, 255));
		if ((cmd == CMD_QUERY || cmd == CMD_QUERY_ALT) && $urandom_range(0, 1)) begin
			s.qr = CRD_W'(cur_row + $urandom_range(0, 4) - 2);
			s.qc = CRD_W'(cur_col + $urandom_range(0, 4) - 2);
		end else begin
			s.qr = CRD_W'($urandom_range(0, 63));
			s.qc = CRD_W'($urandom_range(0, 63));
		end
		return s;
	endfunction

	function automatic logic [CMD_W-1:0] query_code();
		return $urandom_range(0, 1) ? CMD_QUERY : CMD_QUERY_ALT;
	endfunction

	// Called at a falling edge; returns at the falling edge after the
	// request was taken, with valid still high.
	task automatic send_request(input stim_t item);
		int gap;
		gap = calm ? 0 : idle_len();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.command      <= item.cmd;
		req_ch.random_value <= item.rnd;
		req_ch.query_row    <= item.qr;
		req_ch.query_col    <= item.qc;
		req_note            <= item;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	// Holds the sender off until every owed result has come back.
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (owed.size() != 0) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Monitor: at each rising edge, take a result first and then a
	// request, so a request can never be matched by a result in the same
	// cycle. The watchdog counts cycles in which neither channel moves.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		res_t pred;
		res_t got;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = '{rsp_ch.action, rsp_ch.pos_row, rsp_ch.pos_col,
					rsp_ch.passage_row, rsp_ch.passage_col, rsp_ch.cell_open};
				n_results++;
				if (owed.size() == 0)
					report_error("result with no request outstanding");
				else
					compare_result(got, owed.pop_front());
			end
			if (req_ch.valid && req_ch.ready) begin
				// The model runs on every request, typed-in rows included,
				// so its state keeps track of the block.
				pred = predict_maze(req_ch.command, req_ch.random_value,
					req_ch.query_row, req_ch.query_col);
				if (pred.act == ACT_CARVED)
					n_carves++;
				if (pred.act == ACT_BACK)
					n_backs++;
				if (req_note.known)
					pred = req_note.want;
				owed.push_back(pred);
				n_requests++;
			end
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= IDLE_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
				$display("tb: errors");
				$finish;
			end
		end
	end

	// Result side: ready drops for random stretches, except while calm.
	initial begin : result_stall
		int hold;
		hold = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				rsp_ch.ready <= 1'b0;
				hold--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (!calm && $urandom_range(0, 3) == 0)
					hold = idle_len();
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus.
	// ------------------------------------------------------------------
	initial begin : stimulus
		int count;
		int pick;
		req_ch.valid        = 1'b0;
		req_ch.command      = CMD_RESTART;
		req_ch.random_value = '0;
		req_ch.query_row    = '0;
		req_ch.query_col    = '0;
		req_note            = '0;
		calm                = 1'b0;
		arst_n              = 1'b0;

		// Directed requests. The first ones run before any restart, where a
		// step must report finished and every cell reads closed. Then come
		// the first carve from the origin, queries at the grid edges and
		// beyond them (rows and columns 60..63 read closed), the fourth
		// command code acting as a query, a restart that must close the
		// passage carved earlier, and alternating bit patterns.
		script = '{
			'{CMD_STEP,      8'd0,   6'd0,  6'd0,  1'b1, DONE_HOME},
			'{CMD_QUERY,     8'd0,   6'd0,  6'd0,  1'b1, SHUT_HOME},
			'{CMD_QUERY,     8'd255, 6'd63, 6'd63, 1'b1, SHUT_HOME},
			'{CMD_RESTART,   8'd0,   6'd0,  6'd0,  1'b1, DONE_HOME},
			'{CMD_QUERY,     8'd0,   6'd0,  6'd0,  1'b1, OPEN_HOME},
			'{CMD_QUERY_ALT, 8'd0,   6'd59, 6'd59, 1'b1, SHUT_HOME},
			'{CMD_STEP,      8'd0,   6'd0,  6'd0,  1'b1, FIRST_CARVE},
			'{CMD_QUERY,     8'd0,   6'd1,  6'd0,  1'b1, OPEN_NEAR},
			'{CMD_STEP,      8'd255, 6'd63, 6'd63, 1'b0, NOT_KNOWN},
			'{CMD_STEP,      8'd128, 6'd0,  6'd0,  1'b0, NOT_KNOWN},
			'{CMD_STEP,      8'd1,   6'd0,  6'd0,  1'b0, NOT_KNOWN},
			'{CMD_STEP,      8'd2,   6'd0,  6'd0,  1'b0, NOT_KNOWN},
			'{CMD_STEP,      8'd3,   6'd0,  6'd0,  1'b0, NOT_KNOWN},
			'{CMD_QUERY,     8'd0,   6'd59, 6'd0,  1'b0, NOT_KNOWN},
			'{CMD_QUERY,     8'd0,   6'd0,  6'd59, 1'b0, NOT_KNOWN},
			'{CMD_QUERY,     8'd0,   6'd63, 6'd0,  1'b0, NOT_KNOWN},
			'{CMD_QUERY_ALT, 8'd0,   6'd0,  6'd63, 1'b0, NOT_KNOWN},
			'{CMD_QUERY_ALT, 8'd0,   6'd2,  6'd0,  1'b0, NOT_KNOWN},
			'{CMD_RESTART,   8'd255, 6'd63, 6'd63, 1'b1, DONE_HOME},
			'{CMD_QUERY,     8'd0,   6'd1,  6'd0,  1'b1, SHUT_HOME},
			'{CMD_QUERY,     8'd0,   6'd2,  6'd0,  1'b1, SHUT_HOME},
			'{CMD_STEP,      8'd85,  6'd0,  6'd0,  1'b0, NOT_KNOWN},
			'{CMD_STEP,      8'd170, 6'd0,  6'd0,  1'b0, NOT_KNOWN},
			'{CMD_QUERY_ALT, 8'd0,   6'd42, 6'd21, 1'b0, NOT_KNOWN},
			'{CMD_QUERY,     8'd0,   6'd21, 6'd42, 1'b0, NOT_KNOWN}
		};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// The block sweeps its bitmap after reset; ready stays low until
		// then, and the first request simply waits for it.
		foreach (script[i]) send_request(script[i]);
		drain();

		// Carve one whole maze: from a restart, mostly steps with random
		// choices and some queries, until the walk has backtracked all the
		// way to the origin and reports finished. A stretch in the middle
		// runs with no gaps on either side, and every 500 requests the
		// sender waits for the block to empty.
		send_request(roll_request(CMD_RESTART));
		count = 0;
		while (!maze_done && count < 2600) begin
			calm = (count >= 400 && count < 700);
			if ($urandom_range(0, 99) < 88)
				send_request(roll_request(CMD_STEP));
			else
				send_request(roll_request(query_code()));
			count++;
			if (count % 500 == 0)
				drain();
		end
		calm = 1'b0;

		// Steps on a finished maze must change nothing.
		repeat (4) send_request(roll_request(CMD_STEP));
		drain();

		// Mixed traffic, with restarts landing in the middle of a walk.
		for (count = 0; count < 250; count++) begin
			calm = (count >= 100 && count < 150);
			pick = $urandom_range(0, 99);
			if (pick < 3)
				send_request(roll_request(CMD_RESTART));
			else if (pick < 70)
				send_request(roll_request(CMD_STEP));
			else
				send_request(roll_request(query_code()));
		end
		calm = 1'b0;

		req_ch.valid <= 1'b0;
		while (owed.size() != 0) @(negedge clk);
		// Wait longer than a carve takes, to catch stray results.
		repeat (30) @(negedge clk);

		$display("summary: %0d requests, %0d results checked, %0d carves, %0d backtracks",
			n_requests, n_results, n_carves, n_backs);
		$display("summary: %0d mazes carved to completion, %0d mismatches",
			mazes_built, err_count);
		if (err_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
